FILE: rtl/core/fmlp_pkg.sv
// Flash map line parser: shared types, constants and the character classifier.
// No dependencies; imported by every module of the block.
package fmlp_pkg;

  localparam int NAME_MAX_CHARS = 63;
  localparam int NAME_LEN_W     = 6;
  localparam int NAME_CNT_W     = ($clog2(NAME_MAX_CHARS + 1) > NAME_LEN_W) ?
                                  $clog2(NAME_MAX_CHARS + 1) : NAME_LEN_W;
  localparam int QUEUE_DEPTH    = 4;
  localparam int QPTR_W         = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W         = $clog2(QUEUE_DEPTH + 1);
  localparam int IN_TDATA_W     = 8;
  localparam int OUT_TDATA_W    = 248;
  localparam int NIBBLE_LAST    = 31;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_VT    = 8'h0b;
  localparam logic [7:0] CH_FF    = 8'h0c;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_DASH  = 8'h2d;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_QUOTE = 8'h27;
  localparam logic [7:0] CH_GRAVE = 8'h60;

  typedef enum logic [2:0] {
    PH_NAME, PH_MD5, PH_MD5_SEP, PH_FILE_LEN, PH_OFFSET, PH_LENGTH, PH_DONE
  } phase_t;

  typedef enum logic [1:0] {NM_AWAIT, NM_DEC, NM_ZERO, NM_HEX} nmode_t;

  typedef enum logic [2:0] {
    ST_OK, ST_SYNTAX, ST_NAME_LONG, ST_OVERFLOW, ST_SKIP
  } status_t;

  typedef enum logic {KIND_CHAR, KIND_RECORD} kind_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       eol;
    logic       blank;
    logic       space;
    logic       name_ok;
    logic       hex_ok;
    logic       dec_ok;
    logic       is_zero;
    logic       is_hash;
    logic       is_dash;
    logic       is_x;
    logic [3:0] nib;
  } citem_t;

  // first member is the highest bits: name_char ends up in bits 7:0
  typedef struct packed {
    logic [5:0]            pad;
    logic [NAME_LEN_W-1:0] name_length;
    logic [31:0]           region_length;
    logic [31:0]           region_offset;
    logic [31:0]           file_len;
    logic [63:0]           md5_low;
    logic [63:0]           md5_high;
    logic                  has_md5;
    status_t               status;
    logic [7:0]            name_char;
  } rec_t;

  function automatic citem_t classify(input logic [7:0] c);
    citem_t r;
    logic   lower;
    logic   upper;
    logic   af;
    lower     = (c >= "a") && (c <= "z");
    upper     = (c >= "A") && (c <= "Z");
    af        = ((c >= "a") && (c <= "f")) || ((c >= "A") && (c <= "F"));
    r.ch      = c;
    r.eol     = (c == CH_NUL) || (c == CH_LF);
    r.blank   = (c == CH_SPACE) || (c == CH_TAB);
    r.space   = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    r.dec_ok  = (c >= "0") && (c <= "9");
    r.hex_ok  = r.dec_ok || af;
    r.is_zero = (c == CH_ZERO);
    r.is_hash = (c == CH_HASH);
    r.is_dash = (c == CH_DASH);
    r.is_x    = (c == "x") || (c == "X");
    r.nib     = r.dec_ok ? c[3:0] : 4'(c[3:0] + 4'd9);
    r.name_ok = lower || upper || r.dec_ok ||
                (c inside {"$", "%", CH_QUOTE, "-", "_", "@", "~", CH_GRAVE, "!",
                           "(", ")", "{", "}", "^", "#", "&", "+", ",", ";",
                           "=", "[", "]", "."});
    return r;
  endfunction

endpackage

FILE: rtl/core/fmlp_front.sv
// Front end: takes input characters and classifies them for the parser.
// Depends on fmlp_pkg; feeds fmlp_queue.
module fmlp_front (
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [fmlp_pkg::IN_TDATA_W-1:0]    in_tdata,   // ch[7:0]
  input  logic                               q_full,
  output logic                               q_wr,
  output fmlp_pkg::citem_t                   q_wdata
);
  import fmlp_pkg::*;

  assign in_tready = !q_full;
  assign q_wr      = in_tvalid && !q_full;
  assign q_wdata   = classify(in_tdata);

endmodule

FILE: rtl/core/fmlp_queue.sv
// Short queue of classified items between front end and parser.
// Depends on fmlp_pkg.
module fmlp_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr,
  input  fmlp_pkg::citem_t wdata,
  output logic             full,
  input  logic             rd,
  output logic             not_empty,
  output fmlp_pkg::citem_t rdata
);
  import fmlp_pkg::*;

  citem_t            mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              do_wr, do_rd;

  assign full      = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign not_empty = (cnt_r != '0);
  assign do_wr     = wr && !full;
  assign do_rd     = rd && not_empty;
  assign rdata     = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : QPTR_W'(wr_ptr_r + 1'b1);
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : QPTR_W'(rd_ptr_r + 1'b1);
    end
    if (do_wr && !do_rd) begin
      cnt_nxt = QCNT_W'(cnt_r + 1'b1);
    end else if (do_rd && !do_wr) begin
      cnt_nxt = QCNT_W'(cnt_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr_r] <= wdata;
    end
  end

endmodule

FILE: rtl/core/fmlp_back.sv
// Back end: line parser state machine and registered result stage.
// Depends on fmlp_pkg; pops items from fmlp_queue.
module fmlp_back (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              q_valid,
  input  fmlp_pkg::citem_t                  q_item,
  output logic                              q_pop,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic                              out_tuser,  // kind
  output logic [fmlp_pkg::OUT_TDATA_W-1:0]  out_tdata
);
  import fmlp_pkg::*;

  phase_t                phase_r, phase_nxt;
  logic                  at_start_r, at_start_nxt;
  logic                  discard_r, discard_nxt;
  logic [NAME_CNT_W-1:0] name_cnt_r, name_cnt_nxt;
  logic [127:0]          digest_r, digest_nxt;
  logic [4:0]            nib_cnt_r, nib_cnt_nxt;
  nmode_t                nmode_r, nmode_nxt;
  logic [31:0]           acc_r, acc_nxt;
  logic [31:0]           flen_r, flen_nxt;
  logic [31:0]           offs_r, offs_nxt;
  logic [31:0]           rlen_r, rlen_nxt;
  logic                  dflag_r, dflag_nxt;

  logic                  out_valid_r;
  kind_t                 out_kind_r;
  rec_t                  out_rec_r;

  logic                  take;
  logic                  num_phase;
  logic                  num_end;
  logic [35:0]           dec_prod;
  logic                  dec_ovf;
  logic                  hex_ovf;
  logic [31:0]           len_sel;
  logic [32:0]           sum;
  logic                  sum_ovf;
  logic                  rec;
  logic                  echo;
  status_t               rec_st;
  rec_t                  res_rec;

  assign take  = q_valid && (!out_valid_r || out_tready);
  assign q_pop = take;

  assign num_phase = (phase_r == PH_FILE_LEN) || (phase_r == PH_OFFSET) ||
                     (phase_r == PH_LENGTH);
  assign dec_prod  = ({4'd0, acc_r} << 3) + ({4'd0, acc_r} << 1) + {32'd0, q_item.nib};
  assign dec_ovf   = (dec_prod[35:32] != 4'd0);
  assign hex_ovf   = (acc_r[31:28] != 4'd0);
  assign len_sel   = (phase_r == PH_LENGTH) ? acc_r : rlen_r;
  assign sum       = {1'b0, offs_r} + {1'b0, len_sel};
  assign sum_ovf   = sum[32];

  always_comb begin
    num_end = 1'b0;
    case (nmode_r)
      NM_DEC:  num_end = !q_item.dec_ok;
      NM_ZERO: num_end = !q_item.is_x;
      NM_HEX:  num_end = !q_item.hex_ok;
      default: num_end = 1'b0;
    endcase
  end

  // result decision
  always_comb begin
    rec    = 1'b0;
    echo   = 1'b0;
    rec_st = ST_OK;
    if (!discard_r) begin
      if (at_start_r && q_item.eol) begin
        rec    = 1'b1;
        rec_st = ST_SKIP;
      end else if (at_start_r && q_item.space) begin
        rec = 1'b0;
      end else if (at_start_r && q_item.is_hash) begin
        rec    = 1'b1;
        rec_st = ST_SKIP;
      end else begin
        case (phase_r)
          PH_NAME: begin
            if (q_item.blank) begin
              rec = 1'b0;
            end else if (q_item.name_ok) begin
              if (name_cnt_r >= NAME_CNT_W'(NAME_MAX_CHARS)) begin
                rec    = 1'b1;
                rec_st = ST_NAME_LONG;
              end else begin
                echo = 1'b1;
              end
            end else begin
              rec    = 1'b1;
              rec_st = ST_SYNTAX;
            end
          end
          PH_MD5: begin
            if (!(((nib_cnt_r == 5'd0) && (q_item.blank || q_item.is_dash)) ||
                  q_item.hex_ok)) begin
              rec    = 1'b1;
              rec_st = ST_SYNTAX;
            end
          end
          PH_MD5_SEP: begin
            if (!q_item.blank) begin
              rec    = 1'b1;
              rec_st = ST_SYNTAX;
            end
          end
          PH_FILE_LEN, PH_OFFSET, PH_LENGTH: begin
            if (nmode_r == NM_AWAIT) begin
              if (!(q_item.dec_ok || q_item.blank)) begin
                rec    = 1'b1;
                rec_st = ST_SYNTAX;
              end
            end else if (num_end) begin
              if (q_item.blank) begin
                rec = 1'b0;
              end else if (q_item.eol && (phase_r == PH_LENGTH)) begin
                rec    = 1'b1;
                rec_st = sum_ovf ? ST_OVERFLOW : ST_OK;
              end else begin
                rec    = 1'b1;
                rec_st = ST_SYNTAX;
              end
            end else if (((nmode_r == NM_DEC) && dec_ovf) ||
                         ((nmode_r == NM_HEX) && hex_ovf)) begin
              rec    = 1'b1;
              rec_st = ST_OVERFLOW;
            end
          end
          default: begin
            if (q_item.eol) begin
              rec    = 1'b1;
              rec_st = sum_ovf ? ST_OVERFLOW : ST_OK;
            end else if (!q_item.space) begin
              rec    = 1'b1;
              rec_st = ST_SYNTAX;
            end
          end
        endcase
      end
    end
  end

  always_comb begin
    res_rec = '0;
    if (echo) begin
      res_rec.name_char = q_item.ch;
    end
    if (rec) begin
      res_rec.status      = rec_st;
      res_rec.name_length = name_cnt_r[NAME_LEN_W-1:0];
      if (rec_st == ST_OK) begin
        res_rec.has_md5       = dflag_r;
        res_rec.md5_high      = digest_r[127:64];
        res_rec.md5_low       = digest_r[63:0];
        res_rec.file_len      = flen_r;
        res_rec.region_offset = offs_r;
        res_rec.region_length = len_sel;
      end
    end
  end

  // parser next state
  always_comb begin
    phase_nxt    = phase_r;
    at_start_nxt = at_start_r;
    discard_nxt  = discard_r;
    name_cnt_nxt = name_cnt_r;
    digest_nxt   = digest_r;
    nib_cnt_nxt  = nib_cnt_r;
    nmode_nxt    = nmode_r;
    acc_nxt      = acc_r;
    flen_nxt     = flen_r;
    offs_nxt     = offs_r;
    rlen_nxt     = rlen_r;
    dflag_nxt    = dflag_r;
    if (take) begin
      if ((discard_r || rec) && q_item.eol) begin
        phase_nxt    = PH_NAME;
        at_start_nxt = 1'b1;
        discard_nxt  = 1'b0;
        name_cnt_nxt = '0;
        digest_nxt   = '0;
        nib_cnt_nxt  = '0;
        nmode_nxt    = NM_AWAIT;
        acc_nxt      = '0;
        flen_nxt     = '0;
        offs_nxt     = '0;
        rlen_nxt     = '0;
        dflag_nxt    = 1'b1;
      end else if (discard_r) begin
        discard_nxt = 1'b1;
      end else if (rec) begin
        discard_nxt = 1'b1;
      end else if (!(at_start_r && q_item.space)) begin
        at_start_nxt = 1'b0;
        case (phase_r)
          PH_NAME: begin
            if (q_item.blank) begin
              phase_nxt = PH_MD5;
            end else if (echo) begin
              name_cnt_nxt = NAME_CNT_W'(name_cnt_r + 1'b1);
            end
          end
          PH_MD5: begin
            if ((nib_cnt_r == 5'd0) && q_item.blank) begin
              phase_nxt = PH_MD5;
            end else if ((nib_cnt_r == 5'd0) && q_item.is_dash) begin
              dflag_nxt  = 1'b0;
              digest_nxt = '0;
              flen_nxt   = '0;
              phase_nxt  = PH_MD5_SEP;
            end else begin
              digest_nxt = {digest_r[123:0], q_item.nib};
              if (nib_cnt_r == 5'(NIBBLE_LAST)) begin
                nib_cnt_nxt = '0;
                phase_nxt   = PH_MD5_SEP;
              end else begin
                nib_cnt_nxt = 5'(nib_cnt_r + 1'b1);
              end
            end
          end
          PH_MD5_SEP: begin
            phase_nxt = dflag_r ? PH_FILE_LEN : PH_OFFSET;
            nmode_nxt = NM_AWAIT;
            acc_nxt   = '0;
          end
          PH_FILE_LEN, PH_OFFSET, PH_LENGTH: begin
            if (num_end) begin
              case (phase_r)
                PH_FILE_LEN: flen_nxt = acc_r;
                PH_OFFSET:   offs_nxt = acc_r;
                default:     rlen_nxt = acc_r;
              endcase
              phase_nxt = phase_t'(phase_r + 3'd1);
              nmode_nxt = NM_AWAIT;
              acc_nxt   = '0;
            end else begin
              case (nmode_r)
                NM_AWAIT: begin
                  if (q_item.is_zero) begin
                    nmode_nxt = NM_ZERO;
                    acc_nxt   = '0;
                  end else if (q_item.dec_ok) begin
                    nmode_nxt = NM_DEC;
                    acc_nxt   = {28'd0, q_item.nib};
                  end
                end
                NM_DEC:  acc_nxt   = dec_prod[31:0];
                NM_ZERO: nmode_nxt = NM_HEX;
                default: acc_nxt   = {acc_r[27:0], q_item.nib};
              endcase
            end
          end
          default: begin
            phase_nxt = phase_r;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_NAME;
      at_start_r  <= 1'b1;
      discard_r   <= 1'b0;
      name_cnt_r  <= '0;
      digest_r    <= '0;
      nib_cnt_r   <= '0;
      nmode_r     <= NM_AWAIT;
      acc_r       <= '0;
      flen_r      <= '0;
      offs_r      <= '0;
      rlen_r      <= '0;
      dflag_r     <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      phase_r    <= phase_nxt;
      at_start_r <= at_start_nxt;
      discard_r  <= discard_nxt;
      name_cnt_r <= name_cnt_nxt;
      digest_r   <= digest_nxt;
      nib_cnt_r  <= nib_cnt_nxt;
      nmode_r    <= nmode_nxt;
      acc_r      <= acc_nxt;
      flen_r     <= flen_nxt;
      offs_r     <= offs_nxt;
      rlen_r     <= rlen_nxt;
      dflag_r    <= dflag_nxt;
      if (take) begin
        out_valid_r <= rec || echo;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && (rec || echo)) begin
      out_kind_r <= rec ? KIND_RECORD : KIND_CHAR;
      out_rec_r  <= res_rec;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tdata  = out_rec_r;

endmodule

FILE: rtl/core/flash_map_line_parser_unit.sv
// An accepted character reaches its result through the queue entry and then the result register.
// Throughput: one character per cycle while the output register is not held; the parser state
// update with its x10 multiply-add and the offset+length carry check form the feedback loop.
// Results stall only while the output register is held; the 4-entry queue absorbs input.
// Reset: synchronous active-low rst_n; parser returns to the start-of-line state,
// queue and output register empty.
module flash_map_line_parser_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [fmlp_pkg::IN_TDATA_W-1:0]   in_tdata,   // ch[7:0]
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic                              out_tuser,  // kind
  // name_char[7:0], status[10:8], has_md5[11], md5_high[75:12], md5_low[139:76],
  // file_len[171:140], region_offset[203:172], region_length[235:204],
  // name_length[241:236], zero pad[247:242]
  output logic [fmlp_pkg::OUT_TDATA_W-1:0]  out_tdata
);
  import fmlp_pkg::*;

  logic   q_full;
  logic   q_wr;
  citem_t q_wdata;
  logic   q_pop;
  logic   q_valid;
  citem_t q_rdata;

  fmlp_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_full    (q_full),
    .q_wr      (q_wr),
    .q_wdata   (q_wdata)
  );

  fmlp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr        (q_wr),
    .wdata     (q_wdata),
    .full      (q_full),
    .rd        (q_pop),
    .not_empty (q_valid),
    .rdata     (q_rdata)
  );

  fmlp_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_item     (q_rdata),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tuser  (out_tuser),
    .out_tdata  (out_tdata)
  );

endmodule

FILE: rtl/core/fmlp_checker.sv
// Port-level checks for the flash map line parser result stream.
// Depends on fmlp_pkg; bound to flash_map_line_parser_unit.
module fmlp_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic                              out_tuser,
  input logic [fmlp_pkg::OUT_TDATA_W-1:0]  out_tdata
);
  import fmlp_pkg::*;

  rec_t r;
  assign r = out_tdata;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result dropped or changed while stalled");

  a_echo_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == KIND_CHAR) |->
      (out_tdata[OUT_TDATA_W-1:8] == '0) && (r.name_char != 8'd0))
    else $error("echoed character carries record fields");

  a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == KIND_RECORD) && (r.status != ST_OK) |->
      !r.has_md5 && (r.md5_high == '0) && (r.md5_low == '0) &&
      (r.file_len == '0) && (r.region_offset == '0) && (r.region_length == '0))
    else $error("failed record carries parsed values");

  a_ok_fits: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == KIND_RECORD) && (r.status == ST_OK) |->
      ({1'b0, r.region_offset} + {1'b0, r.region_length}) <= 33'hffff_ffff &&
      (r.has_md5 || ((r.file_len == '0) && (r.md5_high == '0) && (r.md5_low == '0))))
    else $error("ok record with overflowing region or stray digest");

endmodule

bind flash_map_line_parser_unit fmlp_checker u_fmlp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tuser  (out_tuser),
  .out_tdata  (out_tdata)
);

FILE: sim/flash_map_line_parser_unit_tb.sv
// Self-checking testbench for flash_map_line_parser_unit: feeds map lines one character
// per item, predicts echoed name characters and line records, and checks the result stream.
// Depends on fmlp_pkg and flash_map_line_parser_unit.
module flash_map_line_parser_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import fmlp_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 300;
  localparam int MAX_PRINTS  = 40;
  localparam string NAME_SET =
    "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789$%'-_@~\140!(){}^#&+,;=[].";
  localparam string HEX_SET  = "0123456789abcdefABCDEF";

  typedef struct packed {
    kind_t kind;
    rec_t  rec;
  } parse_out_t;

  typedef struct {
    string       txt;
    logic [7:0]  term;
    bit          typed;
    status_t     st;
    int          nlen;
    logic [31:0] off;
    logic [31:0] len;
  } line_row_t;

  logic                    clk;
  logic                    rst_n;
  logic                    in_tvalid;
  logic                    in_tready;
  logic [IN_TDATA_W-1:0]   in_tdata;
  logic                    out_tvalid;
  logic                    out_tready;
  logic                    out_tuser;
  logic [OUT_TDATA_W-1:0]  out_tdata;

  flash_map_line_parser_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tuser  (out_tuser),
    .out_tdata  (out_tdata)
  );

  // parser image
  phase_t       ph;
  logic         at_start;
  logic         discard;
  int           name_cnt;
  logic [127:0] digest;
  int           nib_cnt;
  nmode_t       nmode;
  logic [31:0]  acc;
  logic [31:0]  flen;
  logic [31:0]  offs;
  logic [31:0]  rlen;
  logic         dflag;

  parse_out_t   pending_outputs[$];
  bit           typed_on;
  rec_t         typed_rec;
  line_row_t    map_rows[$];
  logic [7:0]   line_buf[$];

  int           err_cnt;
  int           chars_sent;
  int           send_idle_pct;
  int           recv_stall_pct;
  bit           hold_req;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor
  function automatic bit is_blank(logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB);
  endfunction

  function automatic bit is_space(logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  function automatic bit is_dec(logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic int hex_digit(logic [7:0] c);
    if (is_dec(c)) return int'(c) - 48;
    if ((c >= "a") && (c <= "f")) return int'(c) - 87;
    if ((c >= "A") && (c <= "F")) return int'(c) - 55;
    return -1;
  endfunction

  function automatic bit name_allowed(logic [7:0] c);
    if (((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) || is_dec(c)) return 1'b1;
    case (c)
      "$", "%", CH_QUOTE, "-", "_", "@", "~", CH_GRAVE, "!", "(", ")", "{", "}", "^",
      CH_HASH, "&", "+", ",", ";", "=", "[", "]", ".": return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic void start_line();
    ph       = PH_NAME;
    at_start = 1'b1;
    discard  = 1'b0;
    name_cnt = 0;
    digest   = '0;
    nib_cnt  = 0;
    nmode    = NM_AWAIT;
    acc      = '0;
    flen     = '0;
    offs     = '0;
    rlen     = '0;
    dflag    = 1'b1;
  endfunction

  function automatic void close_line(status_t st, bit eol);
    parse_out_t e;
    e          = '0;
    e.kind     = KIND_RECORD;
    e.rec.status = st;
    if (st == ST_OK) begin
      e.rec.has_md5       = dflag;
      e.rec.md5_high      = digest[127:64];
      e.rec.md5_low       = digest[63:0];
      e.rec.file_len      = flen;
      e.rec.region_offset = offs;
      e.rec.region_length = rlen;
    end
    e.rec.name_length = NAME_LEN_W'(name_cnt);
    if (typed_on) e.rec = typed_rec;
    pending_outputs.push_back(e);
    if (eol) start_line();
    else discard = 1'b1;
  endfunction

  function automatic void line_end_record();
    if (({1'b0, offs} + {1'b0, rlen}) > 33'hffffffff) close_line(ST_OVERFLOW, 1'b1);
    else close_line(ST_OK, 1'b1);
  endfunction

  function automatic void number_char(logic [7:0] c, bit eol);
    logic [35:0] t;
    int          d;
    case (nmode)
      NM_AWAIT: begin
        if (c == CH_ZERO) begin
          nmode = NM_ZERO;
          acc   = '0;
        end else if (is_dec(c)) begin
          nmode = NM_DEC;
          acc   = 32'(c[3:0]);
        end else if (!is_blank(c)) begin
          close_line(ST_SYNTAX, eol);
        end
        return;
      end
      NM_DEC: if (is_dec(c)) begin
        t = 36'(acc) * 36'd10 + 36'(c[3:0]);
        if (t > 36'hffffffff) close_line(ST_OVERFLOW, 1'b0);
        else acc = t[31:0];
        return;
      end
      NM_ZERO: if ((c == "x") || (c == "X")) begin
        nmode = NM_HEX;
        return;
      end
      default: begin
        d = hex_digit(c);
        if (d >= 0) begin
          if (acc[31:28] != 4'd0) close_line(ST_OVERFLOW, 1'b0);
          else acc = {acc[27:0], 4'(d)};
          return;
        end
      end
    endcase
    // number ends on this character
    case (ph)
      PH_FILE_LEN: flen = acc;
      PH_OFFSET:   offs = acc;
      default:     rlen = acc;
    endcase
    if (is_blank(c)) begin
      ph    = phase_t'(ph + 1);
      nmode = NM_AWAIT;
      acc   = '0;
    end else if (eol && (ph == PH_LENGTH)) begin
      line_end_record();
    end else begin
      close_line(ST_SYNTAX, eol);
    end
  endfunction

  function automatic void parse_char(logic [7:0] c);
    bit         eol;
    int         d;
    parse_out_t e;
    eol = (c == CH_NUL) || (c == CH_LF);
    if (discard) begin
      if (eol) start_line();
      return;
    end
    if (at_start) begin
      if (eol) begin
        close_line(ST_SKIP, 1'b1);
        return;
      end
      if (is_space(c)) return;
      if (c == CH_HASH) begin
        close_line(ST_SKIP, 1'b0);
        return;
      end
      at_start = 1'b0;
    end
    case (ph)
      PH_NAME: begin
        if (is_blank(c)) begin
          ph = PH_MD5;
        end else if (name_allowed(c)) begin
          if (name_cnt >= NAME_MAX_CHARS) begin
            close_line(ST_NAME_LONG, 1'b0);
          end else begin
            name_cnt++;
            e               = '0;
            e.kind          = KIND_CHAR;
            e.rec.name_char = c;
            pending_outputs.push_back(e);
          end
        end else begin
          close_line(ST_SYNTAX, eol);
        end
      end
      PH_MD5: begin
        if ((nib_cnt == 0) && is_blank(c)) return;
        if ((nib_cnt == 0) && (c == CH_DASH)) begin
          dflag  = 1'b0;
          digest = '0;
          flen   = '0;
          ph     = PH_MD5_SEP;
          return;
        end
        d = hex_digit(c);
        if (d < 0) begin
          close_line(ST_SYNTAX, eol);
        end else begin
          digest[127 - 4 * nib_cnt -: 4] = 4'(d);
          if (nib_cnt == NIBBLE_LAST) begin
            nib_cnt = 0;
            ph      = PH_MD5_SEP;
          end else begin
            nib_cnt++;
          end
        end
      end
      PH_MD5_SEP: begin
        if (is_blank(c)) begin
          ph    = dflag ? PH_FILE_LEN : PH_OFFSET;
          nmode = NM_AWAIT;
          acc   = '0;
        end else begin
          close_line(ST_SYNTAX, eol);
        end
      end
      PH_FILE_LEN, PH_OFFSET, PH_LENGTH: number_char(c, eol);
      default: begin
        if (eol) line_end_record();
        else if (!is_space(c)) close_line(ST_SYNTAX, 1'b0);
      end
    endcase
  endfunction

  // ---------------------------------------------------------------- checking
  task automatic report(string what);
    err_cnt++;
    if (err_cnt <= MAX_PRINTS) $display("mismatch @%0t: %s", $realtime, what);
  endtask

  task automatic check_result();
    parse_out_t e;
    rec_t       got;
    got = out_tdata;
    if (pending_outputs.size() == 0) begin
      report($sformatf("unexpected item kind %0d data %h", out_tuser, out_tdata));
      return;
    end
    e = pending_outputs.pop_front();
    if ((out_tuser !== e.kind) || (got !== e.rec)) begin
      report($sformatf({"kind %0d/%0d ch %h/%h st %0d/%0d md5 %0d %h%h/%h%h ",
                        "flen %h/%h off %h/%h len %h/%h nlen %0d/%0d pad %h"},
                       out_tuser, e.kind, got.name_char, e.rec.name_char,
                       got.status, e.rec.status, got.has_md5,
                       got.md5_high, got.md5_low, e.rec.md5_high, e.rec.md5_low,
                       got.file_len, e.rec.file_len,
                       got.region_offset, e.rec.region_offset,
                       got.region_length, e.rec.region_length,
                       got.name_length, e.rec.name_length, got.pad));
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) check_result();
  end

  // ---------------------------------------------------------------- receiver
  initial begin : receiver
    int hold_left;
    out_tready = 1'b0;
    hold_left  = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_tready <= 1'b0;
        hold_left--;
      end else begin
        out_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("tb: failure");
    $finish;
  end

  // ---------------------------------------------------------------- sender
  // entered and left at a falling edge
  task automatic send_char(logic [7:0] c);
    while ((send_idle_pct != 0) && ($urandom_range(99) < send_idle_pct)) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= c;
    do @(posedge clk); while (!in_tready);
    parse_char(c);
    chars_sent++;
    @(negedge clk);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending_outputs.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_idle(int snd, int rcv, bit hold);
    @(posedge clk);
    send_idle_pct  = snd;
    recv_stall_pct = rcv;
    hold_req       = hold;
    @(negedge clk);
  endtask

  // ---------------------------------------------------------------- line builder
  function automatic void add_text(string s);
    for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
  endfunction

  function automatic void add_gap(bit any_space, int lo, int hi);
    int          n;
    logic [7:0]  ws[5];
    ws = '{CH_SPACE, CH_TAB, CH_VT, CH_FF, CH_CR};
    n  = $urandom_range(hi, lo);
    for (int i = 0; i < n; i++)
      line_buf.push_back(ws[$urandom_range(any_space ? 4 : 1)]);
  endfunction

  function automatic void add_noise(int lo, int hi);
    int n;
    n = $urandom_range(hi, lo);
    for (int i = 0; i < n; i++) line_buf.push_back(8'($urandom_range(255)));
  endfunction

  function automatic logic [31:0] rand_num();
    case ($urandom_range(5))
      0:       return 32'($urandom_range(9));
      1:       return 32'($urandom_range(999));
      2:       return 32'hffffffff - 32'($urandom_range(3));
      3:       return 32'h1 << $urandom_range(31);
      default: return 32'($urandom());
    endcase
  endfunction

  function automatic string num_text(logic [31:0] v);
    string s;
    case ($urandom_range(9))
      0, 1, 2, 3: s = $sformatf("%0d", v);
      4, 5:       s = $sformatf("0x%0h", v);
      6, 7: begin
        s = $sformatf("0x%0h", v);
        s = s.toupper();
      end
      8:          s = $sformatf("0x00%0h", v);
      default: begin
        case ($urandom_range(4))
          0: s = "0x";
          1: s = "0";
          2: s = "4294967296";
          3: s = $sformatf("0x1%08h", v);
          default: s = "0123";
        endcase
      end
    endcase
    return s;
  endfunction

  function automatic void gen_line();
    int         r;
    int         n;
    int         cut;
    logic [7:0] term;
    line_buf.delete();
    term = ($urandom_range(3) == 0) ? CH_NUL : CH_LF;
    r    = $urandom_range(99);
    if (r < 6) begin
      add_gap(1'b1, 0, 3);
    end else if (r < 11) begin
      add_gap(1'b1, 0, 2);
      line_buf.push_back(CH_HASH);
      add_noise(0, 8);
    end else if (r < 16) begin
      add_noise(1, 20);
    end else begin
      if ($urandom_range(9) < 3) add_gap(1'b1, 1, 2);
      r = $urandom_range(99);
      if (r < 88) n = $urandom_range(10, 1);
      else if (r < 96) n = $urandom_range(NAME_MAX_CHARS, NAME_MAX_CHARS - 7);
      else n = $urandom_range(NAME_MAX_CHARS + 3, NAME_MAX_CHARS + 1);
      for (int i = 0; i < n; i++)
        line_buf.push_back(NAME_SET[$urandom_range(NAME_SET.len() - 1)]);
      add_gap(1'b0, 1, 3);
      if ($urandom_range(9) < 4) begin
        for (int i = 0; i <= NIBBLE_LAST; i++)
          line_buf.push_back(HEX_SET[$urandom_range(HEX_SET.len() - 1)]);
        add_gap(1'b0, 1, 3);
        add_text(num_text(rand_num()));
      end else begin
        line_buf.push_back(CH_DASH);
      end
      add_gap(1'b0, 1, 3);
      add_text(num_text(rand_num()));
      add_gap(1'b0, 1, 3);
      add_text(num_text(rand_num()));
      if ($urandom_range(9) < 3) add_gap(1'b1, 1, 3);
      // broken line: one bad byte or an early end
      if ($urandom_range(3) == 0) begin
        cut = $urandom_range(line_buf.size() - 1);
        if ($urandom_range(1) == 1) line_buf[cut] = 8'($urandom_range(255));
        else while (line_buf.size() > cut) void'(line_buf.pop_back());
      end
    end
    line_buf.push_back(term);
  endfunction

  task automatic run_lines(int upto);
    while (chars_sent < upto) begin
      gen_line();
      foreach (line_buf[i]) send_char(line_buf[i]);
    end
  endtask

  // ---------------------------------------------------------------- directed table
  function automatic void add_row(string txt, logic [7:0] term, bit typed = 1'b0,
                                  status_t st = ST_OK, int nlen = 0,
                                  logic [31:0] off = '0, logic [31:0] len = '0);
    line_row_t rw;
    rw.txt   = txt;
    rw.term  = term;
    rw.typed = typed;
    rw.st    = st;
    rw.nlen  = nlen;
    rw.off   = off;
    rw.len   = len;
    map_rows.push_back(rw);
  endfunction

  function automatic void fill_table();
    string n63;
    n63 = "";
    for (int i = 0; i < NAME_MAX_CHARS; i++) n63 = {n63, "b"};
    add_row("", CH_NUL, 1'b1, ST_SKIP, 0);
    add_row(" \t\013\014\015", CH_LF, 1'b1, ST_SKIP, 0);
    add_row("# note 1 2", CH_LF, 1'b1, ST_SKIP, 0);
    add_row("\t #-", CH_NUL, 1'b1, ST_SKIP, 0);
    add_row({n63, " - 1 2"}, CH_LF, 1'b1, ST_OK, NAME_MAX_CHARS, 32'd1, 32'd2);
    add_row({n63, "b - 1 2"}, CH_LF, 1'b1, ST_NAME_LONG, NAME_MAX_CHARS);
    add_row("a*b - 1 2", CH_LF, 1'b1, ST_SYNTAX, 1);
    add_row("f - 0 0xffffffff", CH_LF, 1'b1, ST_OK, 1, 32'h0, 32'hffffffff);
    add_row("f - 0xFFFFFFFF 0", CH_NUL, 1'b1, ST_OK, 1, 32'hffffffff, 32'h0);
    add_row("f - 4294967295 0", CH_LF, 1'b1, ST_OK, 1, 32'hffffffff, 32'h0);
    add_row("f - 1 0xffffffff", CH_LF, 1'b1, ST_OVERFLOW, 1);
    add_row("f - 4294967296 1", CH_LF, 1'b1, ST_OVERFLOW, 1);
    add_row("f - 0x100000000 0", CH_LF, 1'b1, ST_OVERFLOW, 1);
    add_row("f - 01 2", CH_LF, 1'b1, ST_SYNTAX, 1);
    add_row("f - 0x 0X\t\013\015 ", CH_LF, 1'b1, ST_OK, 1, 32'h0, 32'h0);
    add_row("n - 5", CH_LF, 1'b1, ST_SYNTAX, 1);
    add_row("n abc", CH_NUL, 1'b1, ST_SYNTAX, 1);
    add_row("n", CH_LF, 1'b1, ST_SYNTAX, 1);
    add_row("n 12g4 1 2 3", CH_LF, 1'b1, ST_SYNTAX, 1);
    add_row("n -x 1 2", CH_LF, 1'b1, ST_SYNTAX, 1);
    add_row("n - 1 2 x", CH_LF, 1'b1, ST_SYNTAX, 1);
    add_row("n - 1 2\377", CH_LF, 1'b1, ST_SYNTAX, 1);
    add_row("\200n - 1 2", CH_LF, 1'b1, ST_SYNTAX, 0);
    add_row("n 0123456789abcdefFEDCBA9876543210 123 0x10 77", CH_LF);
    add_row("m ffffffffffffffffffffffffffffffff 0XFFFFFFFF 0 0\t", CH_NUL);
    add_row("$%'-_@~\140!(){}^#&+,;=[].Zz09\t-\t\t0Xa 0x0", CH_LF);
  endfunction

  // ---------------------------------------------------------------- main
  initial begin : stimulus
    line_row_t rw;
    int        base;
    int        span;
    rst_n          = 1'b0;
    in_tvalid      = 1'b0;
    in_tdata       = '0;
    err_cnt        = 0;
    chars_sent     = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_req       = 1'b0;
    typed_on       = 1'b0;
    typed_rec      = '0;
    start_line();
    fill_table();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (map_rows[r]) begin
      rw                      = map_rows[r];
      typed_on                = rw.typed;
      typed_rec               = '0;
      typed_rec.status        = rw.st;
      typed_rec.name_length   = NAME_LEN_W'(rw.nlen);
      typed_rec.region_offset = rw.off;
      typed_rec.region_length = rw.len;
      for (int i = 0; i < rw.txt.len(); i++) send_char(rw.txt[i]);
      send_char(rw.term);
      typed_on = 1'b0;
    end
    drain();

    // random part brings the total to about 1050 items
    base = chars_sent;
    span = (1050 - base) / 5;
    set_idle(0, 0, 1'b0);
    run_lines(base + span);
    drain();
    set_idle(65, 0, 1'b0);
    run_lines(base + 2 * span);
    drain();
    set_idle(0, 65, 1'b0);
    run_lines(base + 3 * span);
    drain();
    set_idle(30, 30, 1'b0);
    run_lines(base + 4 * span);
    drain();
    // receiver held off while lines keep coming
    set_idle(0, 0, 1'b1);
    run_lines(1050);

    drain();
    set_idle(0, 0, 1'b0);
    repeat (8) @(negedge clk);
    if (pending_outputs.size() != 0)
      report($sformatf("%0d expected items never arrived", pending_outputs.size()));
    if (err_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
